FILE: rtl/npdl_pkg.sv
// shared types and constants for the nearest point disturbance lookup
package npdl_pkg;

   localparam int TABLE_DEPTH_DEF = 256;

   localparam int COORD_W  = 20;
   localparam int TRIPLE_W = 3 * COORD_W;
   localparam int ROW_W    = 2 * TRIPLE_W;
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 8;

   localparam int HALF_W = 16;
   localparam int USED_W = 9;
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam int MAG_W = COORD_W;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int ACC_W = SQ_W + 2;

   localparam logic [HALF_W-1:0] HALF_RANGE_RESET = 16'd768;

   typedef enum logic [CMD_W-1:0] {
      CMD_WR_LIN = 2'd0,
      CMD_WR_ROT = 2'd1,
      CMD_QUERY  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      REG_HALF_RANGE = 2'd0,
      REG_LIN_USED   = 2'd1,
      REG_ROT_USED   = 2'd2
   } reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_DIST,
      ST_DONE
   } state_type;

endpackage

FILE: rtl/npdl_req_if.sv
// request channel: row writes and queries
interface npdl_req_if;
   import npdl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic [IDX_W-1:0]          row_index;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic signed [COORD_W-1:0] val_x;
   logic signed [COORD_W-1:0] val_y;
   logic signed [COORD_W-1:0] val_z;

   modport source (
      output valid, cmd, row_index, pos_x, pos_y, pos_z, val_x, val_y, val_z,
      input  ready
   );
   modport sink (
      input  valid, cmd, row_index, pos_x, pos_y, pos_z, val_x, val_y, val_z,
      output ready
   );
endinterface

FILE: rtl/npdl_rsp_if.sv
// response channel: query results
interface npdl_rsp_if;
   import npdl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      found;
   logic signed [COORD_W-1:0] lin_x;
   logic signed [COORD_W-1:0] lin_y;
   logic signed [COORD_W-1:0] lin_z;
   logic signed [COORD_W-1:0] rot_x;
   logic signed [COORD_W-1:0] rot_y;
   logic signed [COORD_W-1:0] rot_z;

   modport source (
      output valid, found, lin_x, lin_y, lin_z, rot_x, rot_y, rot_z,
      input  ready
   );
   modport sink (
      input  valid, found, lin_x, lin_y, lin_z, rot_x, rot_y, rot_z,
      output ready
   );
endinterface

FILE: rtl/npdl_ram.sv
// generic single write port ram with registered read
module npdl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/nearest_point_disturbance_lookup.sv
// nearest point disturbance lookup: two row tables, scanned by one distance unit
//
//   channel   direction  handshake              carries
//   req_if    in         valid/ready transfer   cmd, row_index, pos_x/y/z, val_x/y/z
//   rsp_if    out        valid/ready transfer   found, lin_x/y/z, rot_x/y/z
//   csr_*     in/out     apb write, pready=1    box_half_range, linear/rotation rows used
//
// a row write leaves the block ready
// a query scans the rows in use of the linear table, then those of the rotational table;
// the single distance unit handles one axis per cycle, five steps per row, after a ram
// read of the row
// reset is synchronous and clears control and config; table rows are undefined until written
// a pending result sits in the output register; writes are still taken meanwhile, but a
// finished query waits in its last state until the output register is free
module nearest_point_disturbance_lookup #(
   parameter int TABLE_DEPTH = npdl_pkg::TABLE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   npdl_req_if.sink                      req_if,
   npdl_rsp_if.source                    rsp_if,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [npdl_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [npdl_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [npdl_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import npdl_pkg::*;

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

   // steps of the distance unit for one row
   localparam logic [2:0] STEP_X   = 3'd0;
   localparam logic [2:0] STEP_Y   = 3'd1;
   localparam logic [2:0] STEP_Z   = 3'd2;
   localparam logic [2:0] STEP_SUM = 3'd3;
   localparam logic [2:0] STEP_CMP = 3'd4;

   // config registers
   logic [HALF_W-1:0] half_range_ff, half_range_in;
   logic [USED_W-1:0] lin_used_ff, lin_used_in;
   logic [USED_W-1:0] rot_used_ff, rot_used_in;

   // sequencer and scan state
   state_type         state_ff, state_in;
   logic              tbl_ff, tbl_in;          // 0 linear table, 1 rotational table
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [2:0]        step_ff, step_in;
   logic [COORD_W-1:0] qx_ff, qx_in, qy_ff, qy_in, qz_ff, qz_in;
   logic [MAG_W-1:0]  mag_ff, mag_in;
   logic              out_ff, out_in;          // some axis outside the box
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  best_ff, best_in;
   logic [1:0]        have_ff, have_in;
   logic [TRIPLE_W-1:0] lin_best_ff, lin_best_in;
   logic [TRIPLE_W-1:0] rot_best_ff, rot_best_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [TRIPLE_W-1:0] rsp_lin_ff, rsp_lin_in;
   logic [TRIPLE_W-1:0] rsp_rot_ff, rsp_rot_in;

   // table ports
   logic              lin_wr_en, rot_wr_en, lin_rd_en, rot_rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [ROW_W-1:0]  wr_data, lin_rd_data, rot_rd_data, scan_row;

   // datapath helpers
   logic               req_accept, csr_write, row_ok, wr_in_range, rsp_free;
   logic [USED_W-1:0]  used;
   logic [COORD_W-1:0] row_pos, q_pos;
   logic [COORD_W:0]   diff, diff_neg;
   logic [MAG_W-1:0]   mag;
   logic               mag_out;
   logic [SQ_W-1:0]    sq;

   // ---------------------------------------------------------------- tables
   npdl_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_lin_ram (
      .clock   (clock),
      .wr_en   (lin_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (lin_rd_en),
      .rd_addr (rd_addr),
      .rd_data (lin_rd_data)
   );

   npdl_ram #(.WIDTH(ROW_W), .DEPTH(TABLE_DEPTH)) u_rot_ram (
      .clock   (clock),
      .wr_en   (rot_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rot_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rot_rd_data)
   );

   // ---------------------------------------------------------------- handshakes
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // row layout: pos x, y, z then val x, y, z, x in the top bits
   assign wr_data = {req_if.pos_x, req_if.pos_y, req_if.pos_z,
                     req_if.val_x, req_if.val_y, req_if.val_z};
   assign wr_addr = ADDR_W'(req_if.row_index);
   // writes past the table depth are dropped
   assign wr_in_range = 32'(req_if.row_index) < 32'(TABLE_DEPTH);
   assign lin_wr_en = req_accept && (req_if.cmd == CMD_WR_LIN) && wr_in_range;
   assign rot_wr_en = req_accept && (req_if.cmd == CMD_WR_ROT) && wr_in_range;

   assign rd_addr = row_ff[ADDR_W-1:0];

   // ---------------------------------------------------------------- apb
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_HALF_RANGE: csr_prdata = CSR_DW'(half_range_ff);
         REG_LIN_USED:   csr_prdata = CSR_DW'(lin_used_ff);
         REG_ROT_USED:   csr_prdata = CSR_DW'(rot_used_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_comb begin
      half_range_in = half_range_ff;
      lin_used_in   = lin_used_ff;
      rot_used_in   = rot_used_ff;
      if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_HALF_RANGE: half_range_in = csr_pwdata[HALF_W-1:0];
            REG_LIN_USED:   lin_used_in   = csr_pwdata[USED_W-1:0];
            REG_ROT_USED:   rot_used_in   = csr_pwdata[USED_W-1:0];
            default:        half_range_in = half_range_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- distance unit
   assign scan_row = tbl_ff ? rot_rd_data : lin_rd_data;
   assign used     = tbl_ff ? rot_used_ff : lin_used_ff;
   // rows past the depth are never scanned, whatever the rows-used count says
   assign row_ok   = (32'(row_ff) < 32'(TABLE_DEPTH)) && (32'(row_ff) < 32'(used));

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin
            row_pos = scan_row[ROW_W-1 -: COORD_W];
            q_pos   = qx_ff;
         end
         2'd1: begin
            row_pos = scan_row[ROW_W-1-COORD_W -: COORD_W];
            q_pos   = qy_ff;
         end
         default: begin
            row_pos = scan_row[ROW_W-1-2*COORD_W -: COORD_W];
            q_pos   = qz_ff;
         end
      endcase
   end

   // |row - query| on one axis, never above 2^20-1
   assign diff     = {row_pos[COORD_W-1], row_pos} - {q_pos[COORD_W-1], q_pos};
   assign diff_neg = (COORD_W+1)'(0) - diff;
   assign mag      = diff[COORD_W] ? diff_neg[MAG_W-1:0] : diff[MAG_W-1:0];
   assign mag_out  = mag > MAG_W'(half_range_ff);
   assign sq       = SQ_W'(mag_ff) * SQ_W'(mag_ff);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_if.cmd == CMD_QUERY)) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            if (row_ok) begin
               state_in = ST_DIST;
            end else if (tbl_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DIST: begin
            if (step_ff == STEP_CMP) begin
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      tbl_in      = tbl_ff;
      row_in      = row_ff;
      step_in     = step_ff;
      qx_in       = qx_ff;
      qy_in       = qy_ff;
      qz_in       = qz_ff;
      mag_in      = mag_ff;
      out_in      = out_ff;
      acc_in      = acc_ff;
      best_in     = best_ff;
      have_in     = have_ff;
      lin_best_in = lin_best_ff;
      rot_best_in = rot_best_ff;
      lin_rd_en   = 1'b0;
      rot_rd_en   = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_lin_in   = rsp_lin_ff;
      rsp_rot_in   = rsp_rot_ff;
      rsp_valid_in = rsp_if.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_if.cmd == CMD_QUERY)) begin
               qx_in   = req_if.pos_x;
               qy_in   = req_if.pos_y;
               qz_in   = req_if.pos_z;
               tbl_in  = 1'b0;
               row_in  = '0;
               have_in = 2'b00;
            end
         end
         ST_FETCH: begin
            if (row_ok) begin
               lin_rd_en = !tbl_ff;
               rot_rd_en = tbl_ff;
               row_in    = row_ff + 1'b1;
               step_in   = STEP_X;
            end else if (!tbl_ff) begin
               // linear table done, move on to the rotational one
               tbl_in = 1'b1;
               row_in = '0;
            end
         end
         ST_DIST: begin
            step_in = step_ff + 1'b1;
            unique case (step_ff)
               STEP_X: begin
                  mag_in = mag;
                  out_in = mag_out;
               end
               STEP_Y: begin
                  acc_in = ACC_W'(sq);
                  mag_in = mag;
                  out_in = out_ff || mag_out;
               end
               STEP_Z: begin
                  acc_in = acc_ff + ACC_W'(sq);
                  mag_in = mag;
                  out_in = out_ff || mag_out;
               end
               STEP_SUM: begin
                  acc_in = acc_ff + ACC_W'(sq);
               end
               STEP_CMP: begin
                  // strict less keeps the lowest row on a tie
                  if (!out_ff && (!have_ff[tbl_ff] || (acc_ff < best_ff))) begin
                     have_in[tbl_ff] = 1'b1;
                     best_in         = acc_ff;
                     if (tbl_ff) begin
                        rot_best_in = scan_row[TRIPLE_W-1:0];
                     end else begin
                        lin_best_in = scan_row[TRIPLE_W-1:0];
                     end
                  end
               end
               default: step_in = STEP_X;
            endcase
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = have_ff[0] && have_ff[1];
               rsp_lin_in   = (have_ff[0] && have_ff[1]) ? lin_best_ff : '0;
               rsp_rot_in   = (have_ff[0] && have_ff[1]) ? rot_best_ff : '0;
            end
         end
         default: tbl_in = tbl_ff;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         half_range_ff <= HALF_RANGE_RESET;
         lin_used_ff   <= '0;
         rot_used_ff   <= '0;
         have_ff       <= 2'b00;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         half_range_ff <= half_range_in;
         lin_used_ff   <= lin_used_in;
         rot_used_ff   <= rot_used_in;
         have_ff       <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      tbl_ff       <= tbl_in;
      row_ff       <= row_in;
      step_ff      <= step_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      qz_ff        <= qz_in;
      mag_ff       <= mag_in;
      out_ff       <= out_in;
      acc_ff       <= acc_in;
      best_ff      <= best_in;
      lin_best_ff  <= lin_best_in;
      rot_best_ff  <= rot_best_in;
      rsp_found_ff <= rsp_found_in;
      rsp_lin_ff   <= rsp_lin_in;
      rsp_rot_ff   <= rsp_rot_in;
   end

   // ---------------------------------------------------------------- result port
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.found = rsp_found_ff;
   assign rsp_if.lin_x = rsp_lin_ff[TRIPLE_W-1 -: COORD_W];
   assign rsp_if.lin_y = rsp_lin_ff[TRIPLE_W-1-COORD_W -: COORD_W];
   assign rsp_if.lin_z = rsp_lin_ff[COORD_W-1:0];
   assign rsp_if.rot_x = rsp_rot_ff[TRIPLE_W-1 -: COORD_W];
   assign rsp_if.rot_y = rsp_rot_ff[TRIPLE_W-1-COORD_W -: COORD_W];
   assign rsp_if.rot_z = rsp_rot_ff[COORD_W-1:0];
endmodule

FILE: rtl/npdl_chk.sv
// port level checks for the nearest point disturbance lookup, bound to the top level
module npdl_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [npdl_pkg::CMD_W-1:0]         req_cmd,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_lin_x,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_lin_y,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_lin_z,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_rot_x,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_rot_y,
   input logic signed [npdl_pkg::COORD_W-1:0] rsp_rot_z
);
   import npdl_pkg::*;

   // a query transfer starts a scan, so no transfer on the next cycle
   query_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd == CMD_QUERY)) |=> !req_ready)
      else $error("request ready right after a query transfer");

   // row writes never stall the request side
   write_keeps_ready: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && ((req_cmd == CMD_WR_LIN) || (req_cmd == CMD_WR_ROT)))
      |=> req_ready)
      else $error("request ready dropped after a row write");

   // a new result only appears at the end of a scan
   result_ends_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a scan in progress");

   // no match means all-zero values
   miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> ((rsp_lin_x == 0) && (rsp_lin_y == 0) &&
      (rsp_lin_z == 0) && (rsp_rot_x == 0) && (rsp_rot_y == 0) && (rsp_rot_z == 0)))
      else $error("result without a match carries nonzero values");

   // stalled result holds valid, found, lin_x and rot_x
   rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_found) &&
      $stable(rsp_lin_x) && $stable(rsp_rot_x)))
      else $error("stalled result changed");
endmodule

bind nearest_point_disturbance_lookup npdl_chk u_npdl_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_cmd   (req_if.cmd),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_found (rsp_if.found),
   .rsp_lin_x (rsp_if.lin_x),
   .rsp_lin_y (rsp_if.lin_y),
   .rsp_lin_z (rsp_if.lin_z),
   .rsp_rot_x (rsp_if.rot_x),
   .rsp_rot_y (rsp_if.rot_y),
   .rsp_rot_z (rsp_if.rot_z)
);
